// ===== rtl/u16ls_pkg.sv =====
// ----------------------------------------------------------------------------
// u16ls_pkg
// Shared types and constants for the UTF-16 line splitter: result record,
// decoder state record and the code unit values that end a row.
// ----------------------------------------------------------------------------
package u16ls_pkg;

	localparam logic [15:0] UNIT_CR = 16'h000D;
	localparam logic [15:0] UNIT_LF = 16'h000A;

	// surrogate ranges by their top six bits
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	localparam logic [20:0] SUPP_BASE = 21'h010000;

	// most results one code unit can cause
	localparam int MAX_RES = 3;

	typedef enum logic {
		KIND_CODE = 1'b0,
		KIND_ROW  = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		END_NONE = 2'd0,
		END_LF   = 2'd1,
		END_CR   = 2'd2,
		END_CRLF = 2'd3
	} row_end_t;

	typedef struct packed {
		item_kind_t kind;
		logic [20:0] cp;
		row_end_t rend;
	} result_t;

	// decoder state carried from one code unit to the next
	typedef struct packed {
		logic after_cr;
		logic high_pending;
		logic [9:0] high_bits;
	} dec_state_t;

	function automatic result_t row_result(row_end_t rend);
		result_t r;
		r.kind = KIND_ROW;
		r.cp = '0;
		r.rend = rend;
		return r;
	endfunction

	function automatic result_t code_result(logic [20:0] cp);
		result_t r;
		r.kind = KIND_CODE;
		r.cp = cp;
		r.rend = END_NONE;
		return r;
	endfunction

endpackage

// ===== rtl/u16ls_decode.sv =====
// ----------------------------------------------------------------------------
// u16ls_decode
// Decodes one code unit against the current state: builds the list of up to
// three results in text order, its length, and the next state.
// ----------------------------------------------------------------------------
module u16ls_decode
	import u16ls_pkg::*;
(
	input  dec_state_t cur_state,
	input  logic [15:0] unit,
	input  logic eot,
	output result_t res [MAX_RES],
	output logic [1:0] res_count,
	output dec_state_t nxt_state
);

	always_comb begin
		logic consumed;
		logic [1:0] n;
		logic is_high;
		logic is_low;

		consumed = 1'b0;
		n = 2'd0;
		is_high = (unit[15:10] == HIGH_SURR_TAG);
		is_low = (unit[15:10] == LOW_SURR_TAG);
		nxt_state = cur_state;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = code_result('0);
		end

		// close a row left open by a CR
		if (cur_state.after_cr) begin
			nxt_state.after_cr = 1'b0;
			if (unit == UNIT_LF) begin
				res[n] = row_result(END_CRLF);
				consumed = 1'b1;
			end else begin
				res[n] = row_result(END_CR);
			end
			n = n + 2'd1;
		end

		// decode the unit itself
		if (!consumed) begin
			if (unit == UNIT_CR) begin
				nxt_state.high_pending = 1'b0;
				nxt_state.high_bits = '0;
				nxt_state.after_cr = 1'b1;
			end else if (unit == UNIT_LF) begin
				nxt_state.high_pending = 1'b0;
				nxt_state.high_bits = '0;
				res[n] = row_result(END_LF);
				n = n + 2'd1;
			end else if (is_high) begin
				nxt_state.high_pending = 1'b1;
				nxt_state.high_bits = unit[9:0];
			end else if (is_low) begin
				if (cur_state.high_pending) begin
					res[n] = code_result(SUPP_BASE + {1'b0, cur_state.high_bits, unit[9:0]});
					n = n + 2'd1;
				end
				nxt_state.high_pending = 1'b0;
				nxt_state.high_bits = '0;
			end else begin
				nxt_state.high_pending = 1'b0;
				nxt_state.high_bits = '0;
				res[n] = code_result({5'd0, unit});
				n = n + 2'd1;
			end
		end

		// end of text closes everything and starts over
		if (eot) begin
			if (nxt_state.after_cr) begin
				res[n] = row_result(END_CR);
				n = n + 2'd1;
			end
			res[n] = row_result(END_NONE);
			n = n + 2'd1;
			nxt_state = '0;
		end

		res_count = n;
	end

endmodule

// ===== rtl/utf16_line_splitter_core.sv =====
// ----------------------------------------------------------------------------
// utf16_line_splitter_core
// UTF-16 decoder that splits text into rows and emits code points and
// row-end beats.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one code unit per beat plus an
// end_of_text flag on the final unit of a text. Output channel:
// out_valid/out_stall carry one result per beat: a code point or a row end
// (LF, CR, CRLF or unterminated); last_of_run marks the final result of
// one code unit. Units that produce nothing (CR, high surrogate, dropped
// surrogates) give no output beat.
// A unit accepted into the input register is decoded into the result buffer
// once the buffer is free, and its first result is offered from then on.
// Throughput: one code unit per cycle while each unit gives at most one
// result and out_stall stays low; a unit with k results holds the result
// buffer until all k are taken, so the rate is set by the single output port.
// A stalled receiver holds the current result steady; if the input register
// is empty, one more code unit is taken into it, then in_stall rises.
// Reset clears the decoder state, the input register and the buffer, so
// the first unit after reset starts a new text.
// ----------------------------------------------------------------------------
module utf16_line_splitter_core
	import u16ls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [15:0] code_unit,
	input  logic end_of_text,
	output logic out_valid,
	input  logic out_stall,
	output logic item_kind,
	output logic [20:0] code_point,
	output logic [1:0] row_end_kind,
	output logic last_of_run
);

	logic valid_s1;
	logic [15:0] unit_s1;
	logic eot_s1;

	dec_state_t state_q;
	dec_state_t nxt_state;
	result_t dec_res [MAX_RES];
	logic [1:0] dec_count;

	result_t res_q [MAX_RES];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;

	logic is_last;
	logic pop;
	logic buf_free;
	logic move;

	// decode of the registered unit
	u16ls_decode u_decode (
		.cur_state(state_q),
		.unit(unit_s1),
		.eot(eot_s1),
		.res(dec_res),
		.res_count(dec_count),
		.nxt_state(nxt_state)
	);

	// buffer drain and handoff control
	assign is_last = (idx_q == cnt_q - 2'd1);
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign buf_free = !out_valid || (pop && is_last);
	assign move = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			unit_s1 <= code_unit;
			eot_s1 <= end_of_text;
		end
	end

	// decoder state advances when a unit enters the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (move) begin
			state_q <= nxt_state;
		end
	end

	// result buffer count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (move) begin
			cnt_q <= dec_count;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (is_last) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q <= dec_res;
		end
	end

	// output beat fields
	assign item_kind = res_q[idx_q].kind;
	assign code_point = res_q[idx_q].cp;
	assign row_end_kind = res_q[idx_q].rend;
	assign last_of_run = is_last;

endmodule
